// ===== hw/rtl/dscp_pkg.sv =====
// dscp_pkg: types, codes and sizes shared by the dual stack cell pool
// no dependencies; imported by every module of the block
package dscp_pkg;

   // pool geometry
   localparam int POOL_CELLS = 64;
   localparam int DATA_BITS  = 32;
   localparam int CELL_BITS  = $clog2(POOL_CELLS);
   localparam int COUNT_BITS = $clog2(POOL_CELLS + 1);

   // fixed field widths of the item channels
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int TOP_W    = 32;
   localparam int COUNT_W  = 7;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
   localparam logic [OP_W-1:0] OP_POP     = 2'd1;
   localparam logic [OP_W-1:0] OP_MOVE    = 2'd2;
   localparam logic [OP_W-1:0] OP_RESTORE = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef logic [CELL_BITS-1:0]  cell_idx_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [DATA_BITS-1:0]  word_type;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic signed [TOP_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [TOP_W-1:0] main_top;
      logic                    main_empty;
      logic                    trash_empty;
      logic [COUNT_W-1:0]      main_count;
      logic [COUNT_W-1:0]      trash_count;
   } rsp_type;

   // write and read requests towards the cell memories
   typedef struct packed {
      logic         link_we;
      cell_idx_type link_waddr;
      cell_idx_type link_wdata;
      cell_idx_type link_raddr;
      logic         data_we;
      cell_idx_type data_waddr;
      word_type     data_wdata;
      logic         data_re;
      cell_idx_type data_raddr;
   } mem_req_type;

   // data word as seen on the result channel, sign-extended
   function automatic logic signed [TOP_W-1:0] word_to_top(word_type w);
      return TOP_W'($signed(w));
   endfunction

   // pushed value as stored in a cell
   function automatic word_type value_to_word(logic signed [TOP_W-1:0] v);
      return DATA_BITS'(v);
   endfunction

endpackage

// ===== hw/rtl/dscp_cell_mem.sv =====
// dscp_cell_mem: data and link memories of the shared cell pool
// one write and one registered read per memory each cycle; uses dscp_pkg
module dscp_cell_mem
   import dscp_pkg::*;
(
   input  logic         clock,
   input  mem_req_type  mem_req,
   output cell_idx_type link_rd,
   output word_type     data_rd
);

   cell_idx_type cell_link_ff [POOL_CELLS];
   word_type     cell_data_ff [POOL_CELLS];
   cell_idx_type link_rd_ff;
   word_type     data_rd_ff;

   // link memory: read every cycle, old contents on a same-address write
   always_ff @(posedge clock) begin
      if (mem_req.link_we) begin
         cell_link_ff[mem_req.link_waddr] <= mem_req.link_wdata;
      end
      link_rd_ff <= cell_link_ff[mem_req.link_raddr];
   end

   // data memory: read held until the next head change needs a new word
   always_ff @(posedge clock) begin
      if (mem_req.data_we) begin
         cell_data_ff[mem_req.data_waddr] <= mem_req.data_wdata;
      end
      if (mem_req.data_re) begin
         data_rd_ff <= cell_data_ff[mem_req.data_raddr];
      end
   end

   assign link_rd = link_rd_ff;
   assign data_rd = data_rd_ff;

endmodule

// ===== hw/rtl/dscp_stack_ctrl.sv =====
// dscp_stack_ctrl: head, count and watermark registers of both stacks and the free list
// issues cell memory requests and forms the result fields; uses dscp_pkg
module dscp_stack_ctrl
   import dscp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_type      req,
   input  cell_idx_type link_rd,
   input  word_type     data_rd,
   output mem_req_type  mem_req,
   output rsp_type      rsp
);

   // which cached link the registered memory read replaces next cycle
   localparam logic [1:0] SEL_NONE  = 2'd0;
   localparam logic [1:0] SEL_MAIN  = 2'd1;
   localparam logic [1:0] SEL_TRASH = 2'd2;
   localparam logic [1:0] SEL_FREE  = 2'd3;

   localparam count_type COUNT_ONE  = count_type'(1);
   localparam count_type COUNT_FULL = count_type'(POOL_CELLS);

   cell_idx_type main_head_ff, main_head_in;
   cell_idx_type trash_head_ff, trash_head_in;
   cell_idx_type free_head_ff, free_head_in;
   cell_idx_type main_next_ff, main_next_in;
   cell_idx_type trash_next_ff, trash_next_in;
   cell_idx_type free_next_ff, free_next_in;
   logic [1:0]   rd_sel_ff, rd_sel_in;
   count_type    fresh_ff, fresh_in;
   count_type    main_cells_ff, main_cells_in;
   count_type    trash_cells_ff, trash_cells_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   word_type     pushed_ff, pushed_in;
   logic         top_mem_ff, top_mem_in;

   cell_idx_type main_next, trash_next, free_next;
   cell_idx_type new_cell;
   logic [COUNT_BITS:0] used_cells;
   logic         have_free;
   logic         pool_full;

   // link below each head: fresh from the memory or from the cache
   assign main_next  = (rd_sel_ff == SEL_MAIN)  ? link_rd : main_next_ff;
   assign trash_next = (rd_sel_ff == SEL_TRASH) ? link_rd : trash_next_ff;
   assign free_next  = (rd_sel_ff == SEL_FREE)  ? link_rd : free_next_ff;

   // free list holds cells whenever the watermark is ahead of the stacks
   assign used_cells = {1'b0, main_cells_ff} + {1'b0, trash_cells_ff};
   assign have_free  = {1'b0, fresh_ff} > used_cells;
   assign pool_full  = (fresh_ff == COUNT_FULL);
   assign new_cell   = have_free ? free_head_ff : fresh_ff[CELL_BITS-1:0];

   // one operation per accepted item
   always_comb begin
      main_head_in   = main_head_ff;
      trash_head_in  = trash_head_ff;
      free_head_in   = free_head_ff;
      main_next_in   = main_next;
      trash_next_in  = trash_next;
      free_next_in   = free_next;
      rd_sel_in      = SEL_NONE;
      fresh_in       = fresh_ff;
      main_cells_in  = main_cells_ff;
      trash_cells_in = trash_cells_ff;
      status_in      = status_ff;
      pushed_in      = pushed_ff;
      top_mem_in     = top_mem_ff;
      mem_req        = '0;
      if (accept) begin
         status_in = ST_DONE;
         unique case (req.op)
            OP_PUSH: begin
               if (have_free || !pool_full) begin
                  if (have_free) begin
                     free_head_in       = free_next;
                     mem_req.link_raddr = free_next;
                     rd_sel_in          = SEL_FREE;
                  end else begin
                     fresh_in = fresh_ff + COUNT_ONE;
                  end
                  mem_req.link_we    = 1'b1;
                  mem_req.link_waddr = new_cell;
                  mem_req.link_wdata = main_head_ff;
                  mem_req.data_we    = 1'b1;
                  mem_req.data_waddr = new_cell;
                  mem_req.data_wdata = value_to_word(req.value);
                  main_head_in       = new_cell;
                  main_next_in       = main_head_ff;
                  main_cells_in      = main_cells_ff + COUNT_ONE;
                  pushed_in          = value_to_word(req.value);
                  top_mem_in         = 1'b0;
               end else begin
                  status_in = ST_FULL;
               end
            end
            OP_POP: begin
               if (main_cells_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  // head cell goes onto the free list
                  mem_req.link_we    = 1'b1;
                  mem_req.link_waddr = main_head_ff;
                  mem_req.link_wdata = free_head_ff;
                  mem_req.link_raddr = main_next;
                  mem_req.data_re    = 1'b1;
                  mem_req.data_raddr = main_next;
                  rd_sel_in          = SEL_MAIN;
                  main_head_in       = main_next;
                  free_head_in       = main_head_ff;
                  free_next_in       = free_head_ff;
                  main_cells_in      = main_cells_ff - COUNT_ONE;
                  top_mem_in         = 1'b1;
               end
            end
            OP_MOVE: begin
               if (main_cells_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  mem_req.link_we    = 1'b1;
                  mem_req.link_waddr = main_head_ff;
                  mem_req.link_wdata = trash_head_ff;
                  mem_req.link_raddr = main_next;
                  mem_req.data_re    = 1'b1;
                  mem_req.data_raddr = main_next;
                  rd_sel_in          = SEL_MAIN;
                  main_head_in       = main_next;
                  trash_head_in      = main_head_ff;
                  trash_next_in      = trash_head_ff;
                  main_cells_in      = main_cells_ff - COUNT_ONE;
                  trash_cells_in     = trash_cells_ff + COUNT_ONE;
                  top_mem_in         = 1'b1;
               end
            end
            OP_RESTORE: begin
               if (trash_cells_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  mem_req.link_we    = 1'b1;
                  mem_req.link_waddr = trash_head_ff;
                  mem_req.link_wdata = main_head_ff;
                  mem_req.link_raddr = trash_next;
                  mem_req.data_re    = 1'b1;
                  mem_req.data_raddr = trash_head_ff;
                  rd_sel_in          = SEL_TRASH;
                  trash_head_in      = trash_next;
                  main_head_in       = trash_head_ff;
                  main_next_in       = main_head_ff;
                  trash_cells_in     = trash_cells_ff - COUNT_ONE;
                  main_cells_in      = main_cells_ff + COUNT_ONE;
                  top_mem_in         = 1'b1;
               end
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         main_head_ff   <= '0;
         trash_head_ff  <= '0;
         free_head_ff   <= '0;
         rd_sel_ff      <= SEL_NONE;
         fresh_ff       <= '0;
         main_cells_ff  <= '0;
         trash_cells_ff <= '0;
      end else begin
         main_head_ff   <= main_head_in;
         trash_head_ff  <= trash_head_in;
         free_head_ff   <= free_head_in;
         rd_sel_ff      <= rd_sel_in;
         fresh_ff       <= fresh_in;
         main_cells_ff  <= main_cells_in;
         trash_cells_ff <= trash_cells_in;
      end
   end

   // cached links and result payload
   always_ff @(posedge clock) begin
      main_next_ff  <= main_next_in;
      trash_next_ff <= trash_next_in;
      free_next_ff  <= free_next_in;
      status_ff     <= status_in;
      pushed_ff     <= pushed_in;
      top_mem_ff    <= top_mem_in;
   end

   // result fields, top word from the pushed value or the data read
   always_comb begin
      rsp.status      = status_ff;
      rsp.main_empty  = (main_cells_ff == '0);
      rsp.trash_empty = (trash_cells_ff == '0);
      rsp.main_count  = COUNT_W'(main_cells_ff);
      rsp.trash_count = COUNT_W'(trash_cells_ff);
      if (main_cells_ff == '0) begin
         rsp.main_top = '0;
      end else if (top_mem_ff) begin
         rsp.main_top = word_to_top(data_rd);
      end else begin
         rsp.main_top = word_to_top(pushed_ff);
      end
   end

endmodule

// ===== hw/rtl/dual_stack_shared_cell_pool.sv =====
// dual_stack_shared_cell_pool: top level, item handshake and result register
// uses dscp_pkg, dscp_stack_ctrl and dscp_cell_mem
//
// Two linked stacks (main and trash) share one pool of POOL_CELLS cells with a
// free list and an allocation watermark. Each item carries push, pop, move to
// trash or restore and gives one result: status, the word now on top of main,
// and the cell counts of both stacks. An item is taken in every cycle in which
// the result register is empty or is being taken, and its result appears in the
// cycle after acceptance. This rate is set by the head update loop: the link of
// each head is cached in a register, and the one head that follows a link per
// item has its next link fetched through the registered read port of the link
// memory during the same cycle. Cell memories need no clearing after reset:
// only cells already written are ever read.
module dual_stack_shared_cell_pool
   import dscp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic         rsp_valid_ff, rsp_valid_in;
   logic         accept;
   mem_req_type  mem_req;
   cell_idx_type link_rd;
   word_type     data_rd;

   // take an item whenever the result register frees up this cycle
   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   dscp_stack_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .link_rd (link_rd),
      .data_rd (data_rd),
      .mem_req (mem_req),
      .rsp     (rsp_data)
   );

   dscp_cell_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .link_rd (link_rd),
      .data_rd (data_rd)
   );

endmodule

// ===== hw/rtl/dscp_checker.sv =====
// dscp_checker: port-level checks of the dual stack cell pool over time
// uses dscp_pkg; bound to dual_stack_shared_cell_pool at the end of this file
module dscp_checker
   import dscp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic item_in;

   assign item_in = req_valid & ~req_stall;

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a successful push shows the pushed word on top of main
   a_push_top: assert property (@(posedge clock) disable iff (reset)
      item_in && (req_data.op == OP_PUSH) |=>
         (rsp_data.status != ST_DONE) || (rsp_data.main_top == $past(req_data.value)))
      else $error("pushed word not on top of main");

   // a move between stacks keeps the total number of cells in use
   a_move_total: assert property (@(posedge clock) disable iff (reset)
      item_in && ((req_data.op == OP_MOVE) || (req_data.op == OP_RESTORE)) |=>
         (8'(rsp_data.main_count) + 8'(rsp_data.trash_count)) ==
         $past(8'(rsp_data.main_count) + 8'(rsp_data.trash_count)))
      else $error("move changed the number of cells in use");

   // a failed item leaves both counts as they were
   a_fail_keeps: assert property (@(posedge clock) disable iff (reset)
      item_in |=> (rsp_data.status == ST_DONE) ||
         ((rsp_data.main_count == $past(rsp_data.main_count)) &&
          (rsp_data.trash_count == $past(rsp_data.trash_count))))
      else $error("failed item changed a stack");

endmodule

bind dual_stack_shared_cell_pool dscp_checker u_dscp_checker (.*);
